@@ design/camel_to_snake_case_stream_macros.svh @@
// ----------------------------------------------------------------------------
// camel_to_snake_case_stream_macros
// assertion macros for the stream converter, used by ctsc_emit
// ----------------------------------------------------------------------------
`ifndef CAMEL_TO_SNAKE_CASE_STREAM_MACROS_SVH
`define CAMEL_TO_SNAKE_CASE_STREAM_MACROS_SVH

// condition on this edge implies consequence on this edge
`define CTSC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ctsc assertion failed");

// condition on this edge implies consequence on the next edge
`define CTSC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ctsc assertion failed");

`endif

@@ design/ctsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctsc_pkg
// types and character constants of the camel to snake case stream converter
// ----------------------------------------------------------------------------
package ctsc_pkg;

   localparam int unsigned MaxResults = 4;

   localparam logic [7:0] CaseOffset = 8'd32;
   localparam logic [7:0] ChDash     = 8'h2d;
   localparam logic [7:0] ChColon    = 8'h3a;
   localparam logic [7:0] ChSlash    = 8'h2f;
   localparam logic [7:0] ChUnder    = 8'h5f;
   localparam logic [7:0] ChUpperA   = 8'h41;
   localparam logic [7:0] ChUpperZ   = 8'h5a;
   localparam logic [7:0] ChLowerA   = 8'h61;
   localparam logic [7:0] ChLowerZ   = 8'h7a;
   localparam logic [7:0] ChDigit0   = 8'h30;
   localparam logic [7:0] ChDigit9   = 8'h39;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } rsp_type;

   // all result bytes of one item
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [2:0]                 count;
      logic                       string_last;
   } bundle_type;

endpackage

@@ design/ctsc_convert.sv @@
// ----------------------------------------------------------------------------
// ctsc_convert
// input register, lookahead state and the byte conversion of one item
// ----------------------------------------------------------------------------
module ctsc_convert (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ctsc_pkg::req_type   req_data,
   output logic                bundle_valid,
   input  logic                bundle_ready,
   output ctsc_pkg::bundle_type bundle
);

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_LOWER = 3'd1,
      KIND_UPPER = 3'd2,
      KIND_DIGIT = 3'd3,
      KIND_OTHER = 3'd4
   } kind_type;

   typedef struct packed {
      logic [1:0][7:0] bytes;
      logic [1:0]      count;
      kind_type        kind;
   } conv_type;

   function automatic conv_type conv_byte(input logic [7:0] c, input logic has_next,
                                          input logic [7:0] nx, input kind_type prev);
      conv_type r;
      logic     next_lower;
      logic     sep;
      r          = '0;
      next_lower = has_next && nx >= ctsc_pkg::ChLowerA && nx <= ctsc_pkg::ChLowerZ;
      sep        = prev == KIND_LOWER || prev == KIND_DIGIT ||
                   (prev == KIND_UPPER && next_lower);
      r.count    = 2'd1;
      r.bytes[0] = c;
      r.kind     = KIND_OTHER;
      if (c >= ctsc_pkg::ChUpperA && c <= ctsc_pkg::ChUpperZ) begin
         r.kind = KIND_UPPER;
         if (sep) begin
            r.bytes[0] = ctsc_pkg::ChUnder;
            r.bytes[1] = c + ctsc_pkg::CaseOffset;
            r.count    = 2'd2;
         end else begin
            r.bytes[0] = c + ctsc_pkg::CaseOffset;
         end
      end else if (c == ctsc_pkg::ChDash) begin
         r.bytes[0] = ctsc_pkg::ChUnder;
      end else if (c >= ctsc_pkg::ChLowerA && c <= ctsc_pkg::ChLowerZ) begin
         r.kind = KIND_LOWER;
      end else if (c >= ctsc_pkg::ChDigit0 && c <= ctsc_pkg::ChDigit9) begin
         r.kind = KIND_DIGIT;
      end
      return r;
   endfunction

   logic              item_valid_ff;
   ctsc_pkg::req_type item_ff;
   logic              held_valid_ff, held_valid_in;
   logic [7:0]        held_byte_ff, held_byte_in;
   kind_type          kind_ff, kind_in;

   conv_type          first;
   conv_type          second;
   kind_type          mid_kind;
   logic              cur_pending;
   logic              advance;

   always_comb begin
      first       = '0;
      mid_kind    = kind_ff;
      cur_pending = 1'b1;
      if (held_valid_ff) begin
         if (held_byte_ff == ctsc_pkg::ChColon && item_ff.in_byte == ctsc_pkg::ChColon) begin
            first.bytes[0] = ctsc_pkg::ChSlash;
            first.count    = 2'd1;
            first.kind     = KIND_OTHER;
            cur_pending    = 1'b0;
         end else begin
            first = conv_byte(held_byte_ff, 1'b1, item_ff.in_byte, kind_ff);
         end
         mid_kind = first.kind;
      end
      second = '0;
      if (cur_pending && item_ff.string_last) begin
         second = conv_byte(item_ff.in_byte, 1'b0, 8'd0, mid_kind);
      end
   end

   always_comb begin
      bundle             = '0;
      bundle.string_last = item_ff.string_last;
      bundle.count       = {1'b0, first.count} + {1'b0, second.count};
      case (first.count)
         2'd0: begin
            bundle.bytes[0] = second.bytes[0];
            bundle.bytes[1] = second.bytes[1];
         end
         2'd1: begin
            bundle.bytes[0] = first.bytes[0];
            bundle.bytes[1] = second.bytes[0];
            bundle.bytes[2] = second.bytes[1];
         end
         default: begin
            bundle.bytes[0] = first.bytes[0];
            bundle.bytes[1] = first.bytes[1];
            bundle.bytes[2] = second.bytes[0];
            bundle.bytes[3] = second.bytes[1];
         end
      endcase
   end

   assign bundle_valid = item_valid_ff && bundle.count != 3'd0;
   assign advance      = item_valid_ff && (bundle.count == 3'd0 || bundle_ready);
   assign req_stall    = item_valid_ff && !advance;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      kind_in       = kind_ff;
      if (advance) begin
         if (item_ff.string_last) begin
            held_valid_in = 1'b0;
            held_byte_in  = 8'd0;
            kind_in       = KIND_NONE;
         end else begin
            held_valid_in = cur_pending;
            held_byte_in  = cur_pending ? item_ff.in_byte : 8'd0;
            kind_in       = mid_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= 8'd0;
         kind_ff       <= KIND_NONE;
      end else begin
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         kind_ff       <= kind_in;
         if (!req_stall) begin
            item_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff <= req_data;
      end
   end

endmodule

@@ design/ctsc_emit.sv @@
// ----------------------------------------------------------------------------
// ctsc_emit
// result register that hands out the bytes of one item, one per cycle while rsp_stall is low
// ----------------------------------------------------------------------------
`include "camel_to_snake_case_stream_macros.svh"

module ctsc_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 bundle_valid,
   output logic                 bundle_ready,
   input  ctsc_pkg::bundle_type bundle,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ctsc_pkg::rsp_type    rsp_data
);

   ctsc_pkg::bundle_type bundle_ff;
   logic                 busy_ff;
   logic [1:0]           idx_ff;
   logic                 last_beat;
   logic [2:0]           last_idx;

   assign last_idx     = bundle_ff.count - 3'd1;
   assign last_beat    = busy_ff && idx_ff == last_idx[1:0];
   assign bundle_ready = !busy_ff || (last_beat && !rsp_stall);

   assign rsp_valid           = busy_ff;
   assign rsp_data.out_byte   = bundle_ff.bytes[idx_ff];
   assign rsp_data.run_end    = last_beat;
   assign rsp_data.string_end = last_beat && bundle_ff.string_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else if (bundle_valid && bundle_ready) begin
         busy_ff <= 1'b1;
         idx_ff  <= 2'd0;
      end else if (busy_ff && !rsp_stall) begin
         if (last_beat) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_valid && bundle_ready) begin
         bundle_ff <= bundle;
      end
   end

   `CTSC_ASSERT_NOW(a_busy_nonempty, clock, reset, busy_ff, bundle_ff.count != 3'd0 && bundle_ff.count <= 3'd4)
   `CTSC_ASSERT_NOW(a_idx_in_range, clock, reset, busy_ff, {1'b0, idx_ff} < bundle_ff.count)
   `CTSC_ASSERT_NEXT(a_stall_keeps_beat, clock, reset, busy_ff && rsp_stall, busy_ff && $stable(idx_ff))
   `CTSC_ASSERT_NEXT(a_beat_steps, clock, reset, busy_ff && !rsp_stall && !last_beat, busy_ff && idx_ff == $past(idx_ff) + 2'd1)

endmodule

@@ design/camel_to_snake_case_stream.sv @@
// ----------------------------------------------------------------------------
// camel_to_snake_case_stream
// streaming rewrite of camel case identifiers into snake case
// ----------------------------------------------------------------------------
// req channel: one item per identifier byte, string_last marks the final byte.
// rsp channel: converted bytes; run_end marks the last byte caused by an
// item and string_end the final byte of the converted string.
// a byte that is not last of its string is held one item as lookahead, so
// its output leaves together with the next item's; such an item itself can
// give no result at all.
// an accepted item is held in the input register; its results then move to the
// result register, which sends one byte per cycle while rsp_stall is low.
// an item gives 0 to 4 result bytes. a new item is taken in the cycle the last
// byte of the previous one leaves.
// reset clears the lookahead and the previous character kind; pending
// results are dropped. while rsp_stall is high the shown byte holds and the
// input register fills, after which req_stall rises.
// ----------------------------------------------------------------------------
module camel_to_snake_case_stream (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ctsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ctsc_pkg::rsp_type rsp_data
);

   logic                 bundle_valid;
   logic                 bundle_ready;
   ctsc_pkg::bundle_type bundle;

   ctsc_convert u_convert (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .bundle_valid (bundle_valid),
      .bundle_ready (bundle_ready),
      .bundle       (bundle)
   );

   ctsc_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .bundle_valid (bundle_valid),
      .bundle_ready (bundle_ready),
      .bundle       (bundle),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

@@ bench/camel_to_snake_case_stream_test.sv @@
// ----------------------------------------------------------------------------
// camel_to_snake_case_stream_test
// self-checking bench for the streaming camel to snake case converter
// ----------------------------------------------------------------------------
// identifier bytes go in on the req channel and converted bytes are checked on
// the rsp channel against an in-bench model of the rewrite rules: lookahead
// byte, colon pairs, dashes and word breaks before capitals. a few hand-picked
// strings come first, then random identifiers with some raw byte noise, under
// random idling on both sides, one long receiver hold-off and one calm stretch.
// ----------------------------------------------------------------------------
module camel_to_snake_case_stream_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomItems = 350;
   localparam int HoldCycles  = 60;
   localparam int QuietLimit  = 2000;
   localparam int DrainCycles = 10;
   localparam int IdlePercent = 27;

   typedef enum logic [2:0] {
      KindNone, KindLower, KindUpper, KindDigit, KindOther
   } kind_type;

   class snake_case_board;
      bit                 held_valid;
      logic [7:0]         held_byte;
      kind_type           prev_kind;
      logic [7:0]         run[$];
      ctsc_pkg::rsp_type  expected[$];
      int                 items_seen;
      int                 strings_seen;
      int                 results_seen;
      int                 mismatches;

      function void clear();
         held_valid = 1'b0;
         held_byte  = '0;
         prev_kind  = KindNone;
      endfunction

      function void convert_byte(logic [7:0] c, bit has_next, logic [7:0] nx);
         bit next_lower;
         next_lower = has_next && nx >= ctsc_pkg::ChLowerA && nx <= ctsc_pkg::ChLowerZ;
         if (c >= ctsc_pkg::ChUpperA && c <= ctsc_pkg::ChUpperZ) begin
            if (prev_kind == KindLower || prev_kind == KindDigit ||
                (prev_kind == KindUpper && next_lower)) begin
               run.push_back(ctsc_pkg::ChUnder);
            end
            run.push_back(c + ctsc_pkg::CaseOffset);
            prev_kind = KindUpper;
         end else if (c == ctsc_pkg::ChDash) begin
            run.push_back(ctsc_pkg::ChUnder);
            prev_kind = KindOther;
         end else if (c >= ctsc_pkg::ChLowerA && c <= ctsc_pkg::ChLowerZ) begin
            run.push_back(c);
            prev_kind = KindLower;
         end else if (c >= ctsc_pkg::ChDigit0 && c <= ctsc_pkg::ChDigit9) begin
            run.push_back(c);
            prev_kind = KindDigit;
         end else begin
            run.push_back(c);
            prev_kind = KindOther;
         end
      endfunction

      function void note_item(ctsc_pkg::req_type d);
         bit                pending;
         ctsc_pkg::rsp_type r;
         run.delete();
         pending = 1'b1;
         items_seen++;
         if (held_valid) begin
            if (held_byte == ctsc_pkg::ChColon && d.in_byte == ctsc_pkg::ChColon) begin
               run.push_back(ctsc_pkg::ChSlash);
               prev_kind = KindOther;
               pending   = 1'b0;
            end else begin
               convert_byte(held_byte, 1'b1, d.in_byte);
            end
            held_valid = 1'b0;
            held_byte  = '0;
         end
         if (pending) begin
            if (d.string_last) begin
               convert_byte(d.in_byte, 1'b0, 8'h00);
            end else begin
               held_valid = 1'b1;
               held_byte  = d.in_byte;
            end
         end
         foreach (run[i]) begin
            r.out_byte   = run[i];
            r.run_end    = (i == run.size() - 1);
            r.string_end = r.run_end && d.string_last;
            expected.push_back(r);
         end
         if (d.string_last) begin
            clear();
            strings_seen++;
         end
      endfunction

      function void check_result(ctsc_pkg::rsp_type got);
         ctsc_pkg::rsp_type want;
         results_seen++;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected result byte %h run_end %b string_end %b",
                        $time, got.out_byte, got.run_end, got.string_end);
            end
            return;
         end
         want = expected.pop_front();
         if (got.out_byte !== want.out_byte || got.run_end !== want.run_end ||
             got.string_end !== want.string_end) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch byte %h/%h run_end %b/%b string_end %b/%b",
                        $time, want.out_byte, got.out_byte, want.run_end,
                        got.run_end, want.string_end, got.string_end);
               $display("   (expected/actual)");
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ctsc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ctsc_pkg::rsp_type rsp_data;

   snake_case_board board = new();
   bit calm = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int quiet = 0;

   camel_to_snake_case_stream dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // receiver side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HoldCycles;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IdlePercent);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QuietLimit) begin
            $display("no item moved for %0d cycles", QuietLimit);
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [7:0] b, input bit last);
      ctsc_pkg::req_type d;
      d.in_byte     = b;
      d.string_last = last;
      while (!calm && ($urandom_range(99) < IdlePercent)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(d);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] random_char();
      int r;
      r = $urandom_range(99);
      if (r < 30) return ctsc_pkg::ChLowerA + 8'($urandom_range(25));
      if (r < 50) return ctsc_pkg::ChUpperA + 8'($urandom_range(25));
      if (r < 62) return ctsc_pkg::ChDigit0 + 8'($urandom_range(9));
      if (r < 70) return ctsc_pkg::ChDash;
      if (r < 80) return ctsc_pkg::ChColon;
      if (r < 88) return 8'($urandom_range(32, 126));
      return 8'($urandom_range(255));
   endfunction

   initial begin
      logic [7:0] text[$];
      int         sent;
      int         len;
      bit         noise;

      board.clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // word breaks, colon pairs, dashes, edge letters and raw bytes
      send_text("aB");
      send_text("ABc");
      send_text("1Q-");
      send_text("x::Y");
      send_text(":::");
      send_text(":");
      send_text("Z");
      send_text("A9z");
      send_item(8'h00, 1'b0);
      send_item(8'hff, 1'b0);
      send_item(8'h40, 1'b1);

      hold_request = 1'b1;
      sent = 0;
      while (sent < RandomItems) begin
         calm = (sent >= 150 && sent < 250);
         text.delete();
         noise = ($urandom_range(99) < 10);
         len = noise ? $urandom_range(1, 4) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            if (noise) begin
               text.push_back(8'($urandom_range(255)));
            end else if (i > 0 && text[i-1] >= ctsc_pkg::ChUpperA &&
                         text[i-1] <= ctsc_pkg::ChUpperZ &&
                         $urandom_range(99) < 40) begin
               // capital runs, so acronym breaks get exercised
               text.push_back(ctsc_pkg::ChUpperA + 8'($urandom_range(25)));
            end else begin
               text.push_back(random_char());
            end
         end
         foreach (text[i]) begin
            send_item(text[i], i == text.size() - 1);
         end
         sent += len;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (board.expected.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("checked %0d result bytes from %0d items in %0d strings",
               board.results_seen, board.items_seen, board.strings_seen);
      $display("random idling, a %0d-cycle receiver hold-off and a calm stretch ran",
               HoldCycles);
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
